/* sv/dsac_pkg.sv */
// Shared types, constants and the arctangent table for the DEM slope/aspect block.
package dsac_pkg;

    localparam int ELEV_W    = 21;
    localparam int GRAD_W    = 24;
    localparam int ABS_W     = 23;
    localparam int ANG_W     = 13;
    localparam int ASP_W     = 15;
    localparam int COST_W    = 16;
    localparam int ROW_W     = 16;
    localparam int COL_OUT_W = 12;
    localparam int LIM_W     = 13;
    localparam int CELL_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 96;

    // CORDIC datapath
    localparam int CX_W       = 44;
    localparam int CZ_W       = 23;
    localparam int TAB_W      = 20;
    localparam int NORM_BIT   = 39;
    localparam int CORDIC_STEPS = 20;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 29;

    localparam logic [ANG_W-1:0] ANG90  = 13'd5760;
    localparam logic [ASP_W-1:0] ANG180 = 15'd11520;
    localparam logic [ASP_W-1:0] ANG360 = 15'd23040;
    localparam logic [CZ_W-1:0]  Z90    = 23'd1474560;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INF   = 3'd4;

    typedef struct packed {
        logic                     grad;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } calc_req_t;

    typedef struct packed {
        logic [ANG_W-1:0]  slope;
        logic [ASP_W-1:0]  aspect;
        logic              obstacle;
        logic [COST_W-1:0] slope_cost;
        logic [COST_W-1:0] distance_cost;
    } calc_rsp_t;

    // atan(2^-i) in 1/16384 degree, rounded to nearest
    function automatic logic [TAB_W-1:0] atan_entry(input logic [4:0] i);
        logic [TAB_W-1:0] t;
        unique case (i)
            5'd0:    t = 20'd737280;
            5'd1:    t = 20'd435242;
            5'd2:    t = 20'd229970;
            5'd3:    t = 20'd116736;
            5'd4:    t = 20'd58595;
            5'd5:    t = 20'd29326;
            5'd6:    t = 20'd14667;
            5'd7:    t = 20'd7334;
            5'd8:    t = 20'd3667;
            5'd9:    t = 20'd1833;
            5'd10:   t = 20'd917;
            5'd11:   t = 20'd458;
            5'd12:   t = 20'd229;
            5'd13:   t = 20'd115;
            5'd14:   t = 20'd57;
            5'd15:   t = 20'd29;
            5'd16:   t = 20'd14;
            5'd17:   t = 20'd7;
            5'd18:   t = 20'd4;
            5'd19:   t = 20'd2;
            default: t = 20'd0;
        endcase
        return t;
    endfunction

endpackage

/* sv/dsac_calc.sv */
// Shared iterative unit: gradient magnitude, two CORDIC arctangents and the cost divide.
module dsac_calc
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  dsac_pkg::calc_req_t              req,
    input  logic [dsac_pkg::CELL_W-1:0]      cell_size,
    input  logic [dsac_pkg::LIM_W-1:0]       slope_limit,
    input  logic [dsac_pkg::COST_W-1:0]      infinite_cost,
    output logic                             done,
    output dsac_pkg::calc_rsp_t              rsp
);

    typedef enum logic [10:0] {
        C_IDLE  = 11'b00000000001,
        C_ABS   = 11'b00000000010,
        C_MUL1  = 11'b00000000100,
        C_MUL2  = 11'b00000001000,
        C_ADD   = 11'b00000010000,
        C_SQRT  = 11'b00000100000,
        C_ALOAD = 11'b00001000000,
        C_NORM  = 11'b00010000000,
        C_ROT   = 11'b00100000000,
        C_AFIN  = 11'b01000000000,
        C_COST  = 11'b10000000000
    } calc_state_t;

    localparam logic [5:0] DIV_LAST = 6'(dsac_pkg::DIV_STEPS - 1);

    calc_state_t state_reg, state_next;
    logic        div_run_reg;
    logic        done_reg;

    logic signed [dsac_pkg::GRAD_W-1:0] gx_reg, gy_reg;
    logic [dsac_pkg::ABS_W-1:0]         ax_reg, ay_reg;
    logic [45:0]                        prod_reg;
    logic [46:0]                        acc_reg;
    logic [63:0]                        sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [5:0]                         iter_reg;
    logic                               sel_reg;
    logic signed [dsac_pkg::CX_W-1:0]   cx_reg, cy_reg;
    logic signed [dsac_pkg::CZ_W-1:0]   cz_reg;
    logic [dsac_pkg::ANG_W-1:0]         slope_reg;
    logic [dsac_pkg::ASP_W-1:0]         aspect_reg;
    logic                               obst_reg;
    logic [dsac_pkg::COST_W-1:0]        scost_reg, dcost_reg;
    logic [12:0]                        rem_reg;
    logic [28:0]                        num_reg, quo_reg;

    logic [dsac_pkg::CELL_W-1:0] cell_eff;
    logic [26:0]                 dq;
    logic [dsac_pkg::ABS_W-1:0]  mul_a;
    logic [63:0]                 sq_try;
    logic [dsac_pkg::CX_W-1:0]   ld_x, ld_y;
    logic                        ang_store;
    logic [dsac_pkg::ANG_W-1:0]  ang_val;
    logic [dsac_pkg::CZ_W-1:0]   z_clamp;
    logic [dsac_pkg::CZ_W:0]     z_round;
    logic [dsac_pkg::ASP_W-1:0]  alpha, asp_raw;
    logic signed [dsac_pkg::CX_W-1:0] dx, dy;
    logic signed [dsac_pkg::CZ_W-1:0] dz;
    logic [13:0]                 rem_sh;

    // Slope denominator: 6 * cell * 256
    assign cell_eff = (cell_size == '0) ? dsac_pkg::CELL_W'(1) : cell_size;
    assign dq       = {1'b0, cell_eff, 10'd0} + {2'b0, cell_eff, 9'd0};

    assign mul_a  = (state_reg == C_MUL1) ? ax_reg : ay_reg;
    assign sq_try = sq_res_reg + sq_bit_reg;

    // Arctangent operands: slope first, then aspect
    assign ld_x = sel_reg ? dsac_pkg::CX_W'(ax_reg) : dsac_pkg::CX_W'(dq);
    assign ld_y = sel_reg ? dsac_pkg::CX_W'(ay_reg) : dsac_pkg::CX_W'(sq_res_reg[31:0]);

    // CORDIC rotation step
    assign dx = cy_reg >>> iter_reg[4:0];
    assign dy = cx_reg >>> iter_reg[4:0];
    assign dz = $signed({3'b000, dsac_pkg::atan_entry(iter_reg[4:0])});

    // Clamp and round the angle to 1/64 degree
    always_comb
    begin
        if (cz_reg < 0)
            z_clamp = '0;
        else if (cz_reg > $signed(dsac_pkg::Z90))
            z_clamp = dsac_pkg::Z90;
        else
            z_clamp = cz_reg;
        z_round = {1'b0, z_clamp} + (dsac_pkg::CZ_W+1)'(128);
    end

    // Angle result of the current arctangent, with its special cases
    always_comb
    begin
        ang_store = 1'b0;
        ang_val   = '0;
        if (state_reg == C_ALOAD)
        begin
            if (ld_y == '0)
            begin
                ang_store = 1'b1;
                ang_val   = '0;
            end
            else if (ld_x == '0)
            begin
                ang_store = 1'b1;
                ang_val   = dsac_pkg::ANG90;
            end
        end
        else if (state_reg == C_AFIN)
        begin
            ang_store = 1'b1;
            ang_val   = z_round[dsac_pkg::ANG_W+7:8];
        end
    end

    // Aspect from alpha and the gradient signs
    always_comb
    begin
        alpha = dsac_pkg::ASP_W'(ang_val);
        if (gx_reg >= 0)
            asp_raw = (gy_reg >= 0) ? dsac_pkg::ANG180 + alpha : dsac_pkg::ANG180 - alpha;
        else
            asp_raw = (gy_reg > 0) ? dsac_pkg::ANG360 - alpha : alpha;
        if (asp_raw >= dsac_pkg::ANG360)
            asp_raw = asp_raw - dsac_pkg::ANG360;
    end

    assign rem_sh = {rem_reg, num_reg[28]};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
                if (start)
                    state_next = req.grad ? C_ABS : C_COST;
            C_ABS:
                state_next = ((gx_reg == '0) && (gy_reg == '0)) ? C_COST : C_MUL1;
            C_MUL1:
                state_next = C_MUL2;
            C_MUL2:
                state_next = C_ADD;
            C_ADD:
                state_next = C_SQRT;
            C_SQRT:
                if (iter_reg == 6'(dsac_pkg::SQRT_STEPS - 1))
                    state_next = C_ALOAD;
            C_ALOAD:
                if (ang_store)
                    state_next = sel_reg ? C_COST : C_ALOAD;
                else
                    state_next = C_NORM;
            C_NORM:
                if ((cx_reg[dsac_pkg::CX_W-1:dsac_pkg::NORM_BIT] != '0) ||
                    (cy_reg[dsac_pkg::CX_W-1:dsac_pkg::NORM_BIT] != '0))
                    state_next = C_ROT;
            C_ROT:
                if (iter_reg == 6'(dsac_pkg::CORDIC_STEPS - 1))
                    state_next = C_AFIN;
            C_AFIN:
                state_next = sel_reg ? C_COST : C_ALOAD;
            C_COST:
                if (!div_run_reg)
                begin
                    if (slope_reg >= slope_limit)
                        state_next = C_IDLE;
                end
                else if (iter_reg == DIV_LAST)
                    state_next = C_IDLE;
            default:
                state_next = C_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            div_run_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_COST) && (state_next == C_IDLE);
            if (state_reg == C_COST)
                div_run_reg <= (state_next == C_COST);
            else
                div_run_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                gx_reg     <= req.gx;
                gy_reg     <= req.gy;
                slope_reg  <= dsac_pkg::ANG90;
                aspect_reg <= '0;
            end
            C_ABS:
            begin
                ax_reg     <= dsac_pkg::ABS_W'((gx_reg < 0) ? -gx_reg : gx_reg);
                ay_reg     <= dsac_pkg::ABS_W'((gy_reg < 0) ? -gy_reg : gy_reg);
                slope_reg  <= '0;
                aspect_reg <= '0;
            end
            C_MUL1:
                prod_reg <= mul_a * mul_a;
            C_MUL2:
            begin
                acc_reg  <= {1'b0, prod_reg};
                prod_reg <= mul_a * mul_a;
            end
            C_ADD:
            begin
                sq_v_reg   <= {1'b0, acc_reg + {1'b0, prod_reg}, 16'd0};
                sq_res_reg <= '0;
                sq_bit_reg <= 64'd1 << 62;
                iter_reg   <= '0;
                sel_reg    <= 1'b0;
            end
            C_SQRT:
            begin
                if (sq_v_reg >= sq_try)
                begin
                    sq_v_reg   <= sq_v_reg - sq_try;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
                iter_reg   <= iter_reg + 6'd1;
            end
            C_ALOAD:
            begin
                cx_reg   <= $signed(ld_x);
                cy_reg   <= $signed(ld_y);
                cz_reg   <= '0;
                iter_reg <= '0;
            end
            C_NORM:
                if ((cx_reg[dsac_pkg::CX_W-1:dsac_pkg::NORM_BIT] == '0) &&
                    (cy_reg[dsac_pkg::CX_W-1:dsac_pkg::NORM_BIT] == '0))
                begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
            C_ROT:
            begin
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + dz;
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - dz;
                end
                iter_reg <= iter_reg + 6'd1;
            end
            C_AFIN: ;
            C_COST:
                if (!div_run_reg)
                begin
                    obst_reg  <= (slope_reg >= slope_limit);
                    scost_reg <= infinite_cost;
                    dcost_reg <= infinite_cost;
                    rem_reg   <= '0;
                    num_reg   <= {slope_reg, 16'd0};
                    quo_reg   <= '0;
                    iter_reg  <= '0;
                end
                else
                begin
                    if (rem_sh >= {1'b0, slope_limit})
                    begin
                        rem_reg <= 13'(rem_sh - {1'b0, slope_limit});
                        quo_reg <= {quo_reg[27:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[12:0];
                        quo_reg <= {quo_reg[27:0], 1'b0};
                    end
                    num_reg  <= {num_reg[27:0], 1'b0};
                    iter_reg <= iter_reg + 6'd1;
                    if (iter_reg == DIV_LAST)
                    begin
                        scost_reg <= (rem_sh >= {1'b0, slope_limit}) ?
                                     {quo_reg[14:0], 1'b1} : {quo_reg[14:0], 1'b0};
                        dcost_reg <= '0;
                    end
                end
            default: ;
        endcase

        // Store a finished arctangent: slope first, then aspect
        if (ang_store)
        begin
            if (sel_reg)
                aspect_reg <= asp_raw;
            else
            begin
                slope_reg <= ang_val;
                sel_reg   <= 1'b1;
            end
        end
    end

    assign done              = done_reg;
    assign rsp.slope         = slope_reg;
    assign rsp.aspect        = aspect_reg;
    assign rsp.obstacle      = obst_reg;
    assign rsp.slope_cost    = scost_reg;
    assign rsp.distance_cost = dcost_reg;

endmodule

/* sv/dem_slope_aspect_cost.sv */
// Top level of the DEM slope, aspect and traversal cost block.
//
// Elevation samples enter in raster order on the s_axis channel, one signed
// 21-bit sample per item. Results leave on m_axis: pixel position, slope and
// aspect in 1/64 degree, obstacle flag and the two costs; tlast marks the final
// result that an input item causes (zero to three per item). Rows 0 and last
// are reported as they arrive; interior rows are reported one row late.
// Registers are to be written on the cfg port only while the block is idle; the
// block itself does not enforce this. One item is taken at a time: s_axis_tready
// is high only between items. An item passes through accept, line store read and
// line store write, then for each result through start, the shared unit, done and
// output hand-off. For a border pixel the unit runs only the cost divide (skipped
// for an obstacle); for an interior pixel it takes absolute values, two squares,
// a 32-step square root and two arctangents (load, normalize, 20 CORDIC steps),
// then the cost divide, all on the one iterative unit in dsac_calc.
// A result is held in the output register until m_axis_tready; the block
// waits meanwhile. Reset clears the counters and window and restores register
// defaults; the line stores are not cleared and need no clearing pass.
module dem_slope_aspect_cost
#(
    parameter int MAX_COLS = 4096
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [dsac_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [20:0] elevation
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] pixel_row, [27:16] pixel_col, [40:28] slope_angle, [55:41] aspect_angle,
    // [56] obstacle, [72:57] slope_cost, [88:73] distance_cost
    output logic [dsac_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [dsac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dsac_pkg::CFG_DAT_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int NW = $clog2(MAX_COLS + 1);

    typedef enum logic [5:0] {
        T_IDLE  = 6'b000001,
        T_RD    = 6'b000010,
        T_WR    = 6'b000100,
        T_START = 6'b001000,
        T_BUSY  = 6'b010000,
        T_OUT   = 6'b100000
    } top_state_t;

    top_state_t state_reg, state_next;

    // Configuration
    logic [12:0]                        cols_cfg_reg;
    logic [dsac_pkg::ROW_W-1:0]         rows_cfg_reg;
    logic [dsac_pkg::CELL_W-1:0]        cell_reg;
    logic [dsac_pkg::LIM_W-1:0]         limit_reg;
    logic [dsac_pkg::COST_W-1:0]        inf_reg;

    // Position and window
    logic [dsac_pkg::ROW_W-1:0]         row_count_reg, r_reg;
    logic [CW-1:0]                      col_count_reg, c_reg;
    logic signed [dsac_pkg::ELEV_W-1:0] win_reg [6];
    logic signed [dsac_pkg::ELEV_W-1:0] v_reg, top_rd_reg, mid_rd_reg;
    logic signed [dsac_pkg::ELEV_W-1:0] top_mem [MAX_COLS];
    logic signed [dsac_pkg::ELEV_W-1:0] mid_mem [MAX_COLS];

    // Pending results: interior left, interior last column, border row
    logic [2:0] en_reg, cur_reg;
    logic       grad_reg;

    // Output register
    logic [dsac_pkg::ROW_W-1:0]     out_row_reg;
    logic [dsac_pkg::COL_OUT_W-1:0] out_col_reg;
    dsac_pkg::calc_rsp_t            out_rsp_reg;
    logic                           out_last_reg;

    logic [NW-1:0]              cols_eff;
    logic [dsac_pkg::ROW_W-1:0] rows_eff;
    logic                       accept, finish, wrap;
    logic                       in_row, en0, en1, en2;
    logic [2:0]                 cur_sel;
    logic [NW-1:0]              c_ext, c_inc;
    logic [dsac_pkg::ROW_W:0]   r_inc;
    logic signed [dsac_pkg::GRAD_W-1:0] gx, gy;
    dsac_pkg::calc_req_t        req;
    dsac_pkg::calc_rsp_t        rsp;
    logic                       calc_start, calc_done;

    function automatic logic signed [dsac_pkg::GRAD_W-1:0] GRAD_W_EXT(
        input logic signed [dsac_pkg::ELEV_W-1:0] e);
        return dsac_pkg::GRAD_W'(e);
    endfunction

    // Effective image size
    always_comb
    begin
        if (cols_cfg_reg == '0)
            cols_eff = NW'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols_eff = NW'(MAX_COLS);
        else
            cols_eff = NW'(cols_cfg_reg);
        rows_eff = (rows_cfg_reg == '0) ? dsac_pkg::ROW_W'(1) : rows_cfg_reg;
    end

    assign accept = s_axis_tvalid && s_axis_tready;
    assign wrap   = (row_count_reg >= rows_eff) || (NW'(col_count_reg) >= cols_eff);
    assign c_ext  = NW'(c_reg);
    assign c_inc  = c_ext + NW'(1);
    assign r_inc  = {1'b0, r_reg} + 17'd1;

    // Results that this item causes
    assign in_row = (r_reg >= 16'd2) && (r_reg <= rows_eff - 16'd1);
    assign en0    = in_row && (c_reg != '0);
    assign en1    = in_row && (c_ext == cols_eff - NW'(1));
    assign en2    = (r_reg == '0) || (r_reg == rows_eff - 16'd1);

    assign cur_sel = en_reg[0] ? 3'b001 : (en_reg[1] ? 3'b010 : 3'b100);

    // Prewitt gradients over the 3x3 window
    assign gx = (GRAD_W_EXT(win_reg[0]) + GRAD_W_EXT(win_reg[1]) + GRAD_W_EXT(top_rd_reg))
              - (GRAD_W_EXT(win_reg[4]) + GRAD_W_EXT(win_reg[5]) + GRAD_W_EXT(v_reg));
    assign gy = (GRAD_W_EXT(v_reg) + GRAD_W_EXT(mid_rd_reg) + GRAD_W_EXT(top_rd_reg))
              - (GRAD_W_EXT(win_reg[4]) + GRAD_W_EXT(win_reg[2]) + GRAD_W_EXT(win_reg[0]));

    assign req.grad = grad_reg && cur_sel[0];
    assign req.gx   = gx;
    assign req.gy   = gy;
    assign calc_start = (state_reg == T_START);

    dsac_calc u_calc
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (calc_start),
        .req           (req),
        .cell_size     (cell_reg),
        .slope_limit   (limit_reg),
        .infinite_cost (inf_reg),
        .done          (calc_done),
        .rsp           (rsp)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        finish     = 1'b0;
        unique case (state_reg)
            T_IDLE:
                if (accept)
                    state_next = T_RD;
            T_RD:
                state_next = T_WR;
            T_WR:
                if (en0 || en1 || en2)
                    state_next = T_START;
                else
                begin
                    finish     = 1'b1;
                    state_next = T_IDLE;
                end
            T_START:
                state_next = T_BUSY;
            T_BUSY:
                if (calc_done)
                    state_next = T_OUT;
            T_OUT:
                if (m_axis_tready)
                begin
                    if (en_reg != '0)
                        state_next = T_START;
                    else
                    begin
                        finish     = 1'b1;
                        state_next = T_IDLE;
                    end
                end
            default:
                state_next = T_IDLE;
        endcase
    end

    // Control, configuration, counters and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            cols_cfg_reg  <= 13'd4096;
            rows_cfg_reg  <= 16'd4096;
            cell_reg      <= 16'd100;
            limit_reg     <= 13'd1280;
            inf_reg       <= 16'd65535;
            row_count_reg <= '0;
            col_count_reg <= '0;
            en_reg        <= '0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dsac_pkg::CFG_COLS:  cols_cfg_reg <= cfg_data[12:0];
                    dsac_pkg::CFG_ROWS:  rows_cfg_reg <= cfg_data;
                    dsac_pkg::CFG_CELL:  cell_reg     <= cfg_data;
                    dsac_pkg::CFG_LIMIT: limit_reg    <= cfg_data[12:0];
                    dsac_pkg::CFG_INF:   inf_reg      <= cfg_data;
                    default: ;
                endcase
            end

            // Load and drop pending results
            if (state_reg == T_WR)
                en_reg <= {en2, en1, en0};
            else if ((state_reg == T_BUSY) && calc_done)
                en_reg <= en_reg & ~cur_reg;

            // Advance window and position at the end of the item
            if (finish)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= top_rd_reg;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= mid_rd_reg;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= v_reg;
                if (c_inc >= cols_eff)
                begin
                    col_count_reg <= '0;
                    if (r_inc >= {1'b0, rows_eff})
                        row_count_reg <= '0;
                    else
                        row_count_reg <= r_inc[dsac_pkg::ROW_W-1:0];
                end
                else
                    col_count_reg <= c_inc[CW-1:0];
            end
        end
    end

    // Item payload and output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg <= s_axis_tdata[dsac_pkg::ELEV_W-1:0];
            r_reg <= wrap ? '0 : row_count_reg;
            c_reg <= wrap ? '0 : col_count_reg;
        end
        if (state_reg == T_WR)
            grad_reg <= (c_reg >= CW'(2)) && (cols_eff >= NW'(3));
        if (state_reg == T_START)
        begin
            cur_reg     <= cur_sel;
            out_row_reg <= cur_sel[2] ? r_reg : r_reg - 16'd1;
            out_col_reg <= dsac_pkg::COL_OUT_W'(cur_sel[0] ? c_reg - CW'(1) : c_reg);
        end
        if ((state_reg == T_BUSY) && calc_done)
        begin
            out_rsp_reg  <= rsp;
            out_last_reg <= ((en_reg & ~cur_reg) == '0);
        end
    end

    // Line stores: read at the item's column, then shift down
    always_ff @(posedge clk)
    begin
        if (state_reg == T_RD)
        begin
            top_rd_reg <= top_mem[c_reg];
            mid_rd_reg <= mid_mem[c_reg];
        end
        if (state_reg == T_WR)
        begin
            top_mem[c_reg] <= mid_rd_reg;
            mid_mem[c_reg] <= v_reg;
        end
    end

    assign s_axis_tready = (state_reg == T_IDLE);
    assign m_axis_tvalid = (state_reg == T_OUT);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_rsp_reg.distance_cost, out_rsp_reg.slope_cost,
                            out_rsp_reg.obstacle, out_rsp_reg.aspect, out_rsp_reg.slope,
                            out_col_reg, out_row_reg};

endmodule
